@@ hdl/dsc_pkg.sv @@
// Shared types, widths and constants of the degree sine / cosine series pipeline.
// No dependencies; every other file of the block imports this package.
package dsc_pkg;

  // Number of series terms: x - x^3/3! + x^5/5! - ...
  localparam int SERIES_TERMS = 8;

  // Port field widths
  localparam int ANGLE_W = 16;
  localparam int RES_W   = 16;

  // Angle wrapping, units of 1/64 degree
  localparam int WRAP_W = ANGLE_W + 1;
  localparam int MAG_W  = 14;
  localparam logic signed [WRAP_W-1:0] TURN_S      = 17'sd23040;
  localparam logic signed [WRAP_W-1:0] HALF_TURN_S = 17'sd11520;
  localparam logic [MAG_W-1:0]         QUARTER_MAG = 14'd5760;

  // Degrees to radians: x = round(mag * pi_q32 / (45 * 4096)).
  // Split pi_q32 = 45 * RAD_A + 15, so the remainder part folds into mag / 3.
  localparam logic [33:0] PI_Q32    = 34'h3243F6A89;
  localparam int          RAD_DIV   = 45;
  localparam int          RAD_A_W   = 29;
  localparam logic [RAD_A_W-1:0] RAD_A = RAD_A_W'(PI_Q32 / RAD_DIV);
  localparam int          RAD_P_W   = RAD_A_W + MAG_W;
  localparam int          RAD_ROUND = 2048;
  localparam int          RAD_SHIFT = 12;
  localparam int          THIRD_W   = 16;
  localparam logic [THIRD_W-1:0] THIRD_M = 16'd43691;
  localparam int          THIRD_S   = 17;
  localparam int          THIRD_P_W = MAG_W + THIRD_W;

  // Series datapath, unsigned Q28 terms and signed Q28 running sum
  localparam int Q_FRAC  = 28;
  localparam int X_W     = 30;
  localparam int XX_W    = 2 * X_W;
  localparam int X2_W    = 32;
  localparam int TERM_W  = 32;
  localparam int NUM_W   = 32;
  localparam int PROD_W  = 64;
  localparam int RECIP_S = 32;
  localparam int SUM_W   = 34;

  // Magnitude, cosine radicand and square root
  localparam int SMAG_W     = SUM_W;
  localparam int SC_W       = Q_FRAC + 1;
  localparam int SQ_W       = 58;
  localparam int ROOT_STEPS = Q_FRAC + 1;

  // Q28 to Q15 rounding and saturation
  localparam int Q15_SHIFT = 13;
  localparam int Q15_ROUND = 4096;
  localparam logic [RES_W-2:0] Q15_MAX = 15'h7FFF;

  // Control that travels with every pipeline word
  typedef struct packed {
    logic valid;
    logic want_cos;
    logic neg_angle;
    logic cos_neg;
  } dsc_ctl_t;

  function automatic int trail_zeros(input int v);
    int   n;
    logic seen;
    n    = 0;
    seen = 1'b0;
    for (int i = 0; i < 31; i++) begin
      if (!seen && !v[i]) begin
        n = n + 1;
      end else begin
        seen = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

@@ hdl/dsc_front.sv @@
// Front end: input register, wrap to [-180, 180), degrees to radians, x squared.
// Depends on dsc_pkg.
module dsc_front
  import dsc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic                      cmd_i,
  input  logic signed [ANGLE_W-1:0] angle_deg_i,
  output dsc_ctl_t                  ctl_o,
  output logic [X_W-1:0]            x_o,
  output logic [X2_W-1:0]           x2_o
);

  dsc_ctl_t ctl0_q, ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;

  logic signed [ANGLE_W-1:0] ang0_q;
  logic signed [WRAP_W-1:0]  ang_ext, wrap_d, mag_full;
  logic                      neg_d;
  logic [MAG_W-1:0]          mag_d, mag1_q;
  logic [RAD_P_W-1:0]        pa2_q, xsum;
  logic [THIRD_P_W-1:0]      th2_q;
  logic [X_W-1:0]            x3_q, x4_q, x5_q;
  logic [XX_W-1:0]           xx4_q, xx_rnd;
  logic [X2_W-1:0]           x2_5_q;

  // Wrap into [-180, 180) and take the magnitude
  always_comb begin
    ang_ext = {ang0_q[ANGLE_W-1], ang0_q};
    priority if (ang_ext >= HALF_TURN_S) begin
      wrap_d = ang_ext - TURN_S;
    end else if (ang_ext < -HALF_TURN_S) begin
      wrap_d = ang_ext + TURN_S;
    end else begin
      wrap_d = ang_ext;
    end
    neg_d    = wrap_d[WRAP_W-1];
    mag_full = neg_d ? -wrap_d : wrap_d;
    mag_d    = mag_full[MAG_W-1:0];
  end

  assign xsum   = pa2_q + RAD_P_W'(th2_q >> THIRD_S) + RAD_P_W'(RAD_ROUND);
  assign xx_rnd = xx4_q + (XX_W'(1) << (Q_FRAC - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else if (en_i) begin
      ctl0_q <= '{valid: valid_i, want_cos: cmd_i, neg_angle: 1'b0, cos_neg: 1'b0};
      ctl1_q <= '{valid: ctl0_q.valid, want_cos: ctl0_q.want_cos,
                  neg_angle: neg_d, cos_neg: (mag_d > QUARTER_MAG)};
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang0_q <= angle_deg_i;
      mag1_q <= mag_d;
      pa2_q  <= RAD_P_W'(RAD_A) * RAD_P_W'(mag1_q);
      th2_q  <= THIRD_P_W'(mag1_q) * THIRD_P_W'(THIRD_M);
      x3_q   <= xsum[RAD_SHIFT +: X_W];
      xx4_q  <= XX_W'(x3_q) * XX_W'(x3_q);
      x4_q   <= x3_q;
      x2_5_q <= xx_rnd[Q_FRAC +: X2_W];
      x5_q   <= x4_q;
    end
  end

  assign ctl_o = ctl5_q;
  assign x_o   = x5_q;
  assign x2_o  = x2_5_q;

endmodule

@@ hdl/dsc_series.sv @@
// Taylor sine series: five register stages per term plus a final accumulate.
// Each term divides by its constant 2k(2k+1) through a reciprocal and one correction.
// Depends on dsc_pkg.
module dsc_series
  import dsc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  dsc_ctl_t                ctl_i,
  input  logic [X_W-1:0]          x_i,
  input  logic [X2_W-1:0]         x2_i,
  output dsc_ctl_t                ctl_o,
  output logic signed [SUM_W-1:0] sum_o
);

  localparam int NT       = SERIES_TERMS;
  localparam bit LAST_NEG = ((NT - 1) % 2) == 1;

  dsc_ctl_t                ctl_w  [NT];
  logic [TERM_W-1:0]       term_w [NT];
  logic [X2_W-1:0]         x2_w   [NT];
  logic signed [SUM_W-1:0] acc_w  [NT];

  assign ctl_w[0]  = ctl_i;
  assign term_w[0] = TERM_W'(x_i);
  assign x2_w[0]   = x2_i;
  assign acc_w[0]  = '0;

  for (genvar k = 1; k < NT; k++) begin : g_term
    localparam int D        = 2 * k * (2 * k + 1);
    localparam int TZ       = trail_zeros(D);
    localparam int ODD      = D >> TZ;
    localparam logic [NUM_W-1:0]  RECIP  = NUM_W'((64'd1 << RECIP_S) / ODD);
    localparam logic [NUM_W-1:0]  ODD_V  = NUM_W'(ODD);
    localparam logic [PROD_W-1:0] HALF_D = PROD_W'(D) << (Q_FRAC - 1);
    localparam bit                TERM_NEG = ((k - 1) % 2) == 1;

    dsc_ctl_t                ctl_s1_q, ctl_s2_q, ctl_s3_q, ctl_s4_q, ctl_s5_q;
    logic [PROD_W-1:0]       prod_s1_q, rnd_prod, est_prod;
    logic [NUM_W-1:0]        num_s2_q, num_s3_q, num_s4_q, qe_s3_q, qe_s4_q;
    logic [NUM_W-1:0]        back_s4_q, back_d, rem_d;
    logic [TERM_W-1:0]       term_s5_q, term_d;
    logic [X2_W-1:0]         x2_s1_q, x2_s2_q, x2_s3_q, x2_s4_q, x2_s5_q;
    logic signed [SUM_W-1:0] term_ext, acc_d;
    logic signed [SUM_W-1:0] acc_s1_q, acc_s2_q, acc_s3_q, acc_s4_q, acc_s5_q;

    // Fold the previous term into the sum while its successor is multiplied
    assign term_ext = {{(SUM_W - TERM_W){1'b0}}, term_w[k-1]};
    assign acc_d    = TERM_NEG ? acc_w[k-1] - term_ext : acc_w[k-1] + term_ext;

    assign rnd_prod = prod_s1_q + HALF_D;
    assign est_prod = PROD_W'(num_s2_q) * PROD_W'(RECIP);
    assign back_d   = qe_s3_q * ODD_V;
    // Estimate is low by at most one
    assign rem_d    = num_s4_q - back_s4_q;
    assign term_d   = qe_s4_q + NUM_W'(rem_d >= ODD_V);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_s1_q <= '0;
        ctl_s2_q <= '0;
        ctl_s3_q <= '0;
        ctl_s4_q <= '0;
        ctl_s5_q <= '0;
      end else if (en_i) begin
        ctl_s1_q <= ctl_w[k-1];
        ctl_s2_q <= ctl_s1_q;
        ctl_s3_q <= ctl_s2_q;
        ctl_s4_q <= ctl_s3_q;
        ctl_s5_q <= ctl_s4_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_s1_q <= PROD_W'(term_w[k-1]) * PROD_W'(x2_w[k-1]);
        x2_s1_q   <= x2_w[k-1];
        acc_s1_q  <= acc_d;
        num_s2_q  <= rnd_prod[Q_FRAC + TZ +: NUM_W];
        x2_s2_q   <= x2_s1_q;
        acc_s2_q  <= acc_s1_q;
        qe_s3_q   <= est_prod[RECIP_S +: NUM_W];
        num_s3_q  <= num_s2_q;
        x2_s3_q   <= x2_s2_q;
        acc_s3_q  <= acc_s2_q;
        back_s4_q <= back_d;
        qe_s4_q   <= qe_s3_q;
        num_s4_q  <= num_s3_q;
        x2_s4_q   <= x2_s3_q;
        acc_s4_q  <= acc_s3_q;
        term_s5_q <= term_d;
        x2_s5_q   <= x2_s4_q;
        acc_s5_q  <= acc_s4_q;
      end
    end

    assign ctl_w[k]  = ctl_s5_q;
    assign term_w[k] = term_s5_q;
    assign x2_w[k]   = x2_s5_q;
    assign acc_w[k]  = acc_s5_q;
  end

  dsc_ctl_t                ctl_f_q;
  logic signed [SUM_W-1:0] acc_f_q, last_ext;

  assign last_ext = {{(SUM_W - TERM_W){1'b0}}, term_w[NT-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_f_q <= '0;
    end else if (en_i) begin
      ctl_f_q <= ctl_w[NT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_f_q <= LAST_NEG ? acc_w[NT-1] - last_ext : acc_w[NT-1] + last_ext;
    end
  end

  assign ctl_o = ctl_f_q;
  assign sum_o = acc_f_q;

endmodule

@@ hdl/dsc_root.sv @@
// Sine rounding and the cosine radicand, then a one-bit-per-stage square root.
// Depends on dsc_pkg.
module dsc_root
  import dsc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  dsc_ctl_t                ctl_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output dsc_ctl_t                ctl_o,
  output logic signed [RES_W-1:0] sine_o,
  output logic [SC_W-1:0]         root_o
);

  localparam int RND_W = SMAG_W + 1;
  localparam int RQ_W  = RND_W - Q15_SHIFT;
  localparam logic [SMAG_W-1:0] ONE_Q28 = SMAG_W'(1) << Q_FRAC;
  localparam logic [SQ_W-1:0]   ONE_Q56 = SQ_W'(1) << (2 * Q_FRAC);

  dsc_ctl_t                ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic                    sneg1_q, sflip2_q;
  logic [SMAG_W-1:0]       smag1_q;
  logic [RND_W-1:0]        srnd;
  logic [RQ_W-1:0]         srq;
  logic [RES_W-2:0]        smag2_q;
  logic [RES_W-1:0]        smag_ext;
  logic [SC_W-1:0]         sc2_q;
  logic [SQ_W-1:0]         sq3_q, rad4_q;
  logic signed [RES_W-1:0] sine3_q, sine4_q;

  assign srnd     = {1'b0, smag1_q} + RND_W'(Q15_ROUND);
  assign srq      = srnd[RND_W-1:Q15_SHIFT];
  assign smag_ext = {1'b0, smag2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sneg1_q  <= sum_i[SUM_W-1];
      smag1_q  <= sum_i[SUM_W-1] ? SMAG_W'(-sum_i) : SMAG_W'(sum_i);
      smag2_q  <= (srq > RQ_W'(Q15_MAX)) ? Q15_MAX : srq[RES_W-2:0];
      sc2_q    <= (smag1_q > ONE_Q28) ? ONE_Q28[SC_W-1:0] : smag1_q[SC_W-1:0];
      sflip2_q <= sneg1_q ^ ctl1_q.neg_angle;
      sq3_q    <= SQ_W'(sc2_q) * SQ_W'(sc2_q);
      sine3_q  <= sflip2_q ? -smag_ext : smag_ext;
      rad4_q   <= ONE_Q56 - sq3_q;
      sine4_q  <= sine3_q;
    end
  end

  dsc_ctl_t                ctl_w  [ROOT_STEPS+1];
  logic [SQ_W-1:0]         rem_w  [ROOT_STEPS+1];
  logic [SQ_W-1:0]         rt_w   [ROOT_STEPS+1];
  logic signed [RES_W-1:0] sine_w [ROOT_STEPS+1];

  assign ctl_w[0]  = ctl4_q;
  assign rem_w[0]  = rad4_q;
  assign rt_w[0]   = '0;
  assign sine_w[0] = sine4_q;

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
    localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - j));

    dsc_ctl_t                ctl_q;
    logic [SQ_W-1:0]         rem_q, rt_q, cand, rem_d, rt_d;
    logic signed [RES_W-1:0] sine_q;

    // Keep the trial bit when the remainder covers it, drop it otherwise
    always_comb begin
      cand = rt_w[j] + STEP_BIT;
      if (rem_w[j] >= cand) begin
        rem_d = rem_w[j] - cand;
        rt_d  = (rt_w[j] >> 1) + STEP_BIT;
      end else begin
        rem_d = rem_w[j];
        rt_d  = rt_w[j] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q <= '0;
      end else if (en_i) begin
        ctl_q <= ctl_w[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        rt_q   <= rt_d;
        sine_q <= sine_w[j];
      end
    end

    assign ctl_w[j+1]  = ctl_q;
    assign rem_w[j+1]  = rem_q;
    assign rt_w[j+1]   = rt_q;
    assign sine_w[j+1] = sine_q;
  end

  assign ctl_o  = ctl_w[ROOT_STEPS];
  assign sine_o = sine_w[ROOT_STEPS];
  assign root_o = rt_w[ROOT_STEPS][SC_W-1:0];

endmodule

@@ hdl/degree_sine_cosine_series_top.sv @@
// Top level of the degree sine / cosine series pipeline.
// Depends on dsc_pkg, dsc_front, dsc_series and dsc_root.
//
//   channel | direction | handshake         | word fields
//   --------+-----------+-------------------+-------------------------------
//   input   | in        | valid_i / stall_o | cmd_i, angle_deg_i (s16, 1/64 deg)
//   output  | out       | valid_o / stall_i | trig_value_o (s16, Q1.15)
//
// One word enters per clock and one result leaves per clock while stall_i stays low.
// Register stages, in order: six in the front end, five per series term after the
// first plus one accumulate, four for rounding and the radicand, one per square root
// bit (29), then the finish stage and the output register.
// Reset clears every stage's control word (valid bits included) and the output and skid registers; nothing else.
// While the output word is stalled, the next finished word parks in the skid register;
// while that register is full the whole pipeline holds and stall_o is high, so no word
// is lost or repeated.
module degree_sine_cosine_series_top
  import dsc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic                      cmd_i,
  input  logic signed [ANGLE_W-1:0] angle_deg_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic signed [RES_W-1:0]   trig_value_o
);

  localparam int CR_W = SC_W + 1;
  localparam int CQ_W = CR_W - Q15_SHIFT;

  logic                    en;
  dsc_ctl_t                fr_ctl, se_ctl, rt_ctl;
  logic [X_W-1:0]          fr_x;
  logic [X2_W-1:0]         fr_x2;
  logic signed [SUM_W-1:0] se_sum;
  logic signed [RES_W-1:0] rt_sine;
  logic [SC_W-1:0]         rt_root;
  logic                    fin_v_q, out_v_q, skid_v_q, take;
  logic signed [RES_W-1:0] fin_q, out_q, skid_q;

  // The pipeline advances whenever the skid register is empty
  assign en      = !skid_v_q;
  assign stall_o = skid_v_q;

  dsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (valid_i),
    .cmd_i       (cmd_i),
    .angle_deg_i (angle_deg_i),
    .ctl_o       (fr_ctl),
    .x_o         (fr_x),
    .x2_o        (fr_x2)
  );

  dsc_series u_series (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (fr_ctl),
    .x_i    (fr_x),
    .x2_i   (fr_x2),
    .ctl_o  (se_ctl),
    .sum_o  (se_sum)
  );

  dsc_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (se_ctl),
    .sum_i  (se_sum),
    .ctl_o  (rt_ctl),
    .sine_o (rt_sine),
    .root_o (rt_root)
  );

  // Finish: round the root to Q15, saturate, fix the cosine sign, pick the result
  logic [CR_W-1:0]         crnd;
  logic [CQ_W-1:0]         cq;
  logic [RES_W-2:0]        cmag;
  logic [RES_W-1:0]        cmag_ext;
  logic signed [RES_W-1:0] cval, fin_d;

  always_comb begin
    crnd     = {1'b0, rt_root} + CR_W'(Q15_ROUND);
    cq       = crnd[CR_W-1:Q15_SHIFT];
    cmag     = (cq > CQ_W'(Q15_MAX)) ? Q15_MAX : cq[RES_W-2:0];
    cmag_ext = {1'b0, cmag};
    // Strictly between 90 and 270 degrees the cosine is negative
    cval     = rt_ctl.cos_neg ? -cmag_ext : cmag_ext;
    fin_d    = rt_ctl.want_cos ? cval : rt_sine;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= rt_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  assign take = out_v_q && !stall_i;

  // Output register and skid register: park the finished word when the output
  // is still held, and refill the output from the skid once it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
      out_q    <= '0;
      skid_q   <= '0;
    end else if (en) begin
      if (fin_v_q) begin
        if (!out_v_q || take) begin
          out_v_q <= 1'b1;
          out_q   <= fin_q;
        end else begin
          skid_v_q <= 1'b1;
          skid_q   <= fin_q;
        end
      end else if (take) begin
        out_v_q <= 1'b0;
      end
    end else if (take) begin
      out_q    <= skid_q;
      skid_v_q <= 1'b0;
    end
  end

  assign valid_o      = out_v_q;
  assign trig_value_o = out_q;

endmodule

@@ tb/degree_sine_cosine_series_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the degree sine / cosine series pipeline: directed and random
// angle words, a bit-exact trig predictor in a scoreboard class. Depends on dsc_pkg.
module degree_sine_cosine_series_top_tb
  import dsc_pkg::*;
();

  // Register depth of the pipeline, plus margin, for the final drain.
  localparam int PIPE_DEPTH    = 5 * SERIES_TERMS + 37;
  localparam int DRAIN_CYCLES  = PIPE_DEPTH + 20;
  // Cycles with no word moving on either channel before the run is called hung.
  localparam int WATCHDOG_MAX  = 2000;
  localparam int RANDOM_WORDS  = 250;
  localparam longint unsigned RAD_DIVISOR = 64'd184320;  // 11520 * 16
  localparam longint unsigned ONE_Q28     = 64'd1 << Q_FRAC;

  // Holds the expected trig values of accepted angle words, oldest first, and
  // compares each result word against the head of the queue.
  class trig_scoreboard;
    logic signed [RES_W-1:0] expected_trig[$];
    int                      errors = 0;

    // Largest r with r * r <= n; n never exceeds 2^56, so r fits in 29 bits.
    static function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned cand;
      root = 0;
      for (int b = Q_FRAC; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= n) root = cand;
      end
      return root;
    endfunction

    // Round an unsigned Q28 magnitude to Q15 and saturate.
    static function int q28_to_q15(longint unsigned m);
      longint unsigned q;
      q = (m + Q15_ROUND) >> Q15_SHIFT;
      if (q > longint'(Q15_MAX)) q = Q15_MAX;
      return int'(q);
    endfunction

    static function logic signed [RES_W-1:0] predict_trig(logic want_cos,
                                                         logic signed [ANGLE_W-1:0] angle);
      int              wrapped;
      logic            neg_angle;
      logic            sum_neg;
      longint unsigned mag, x, x2, term, d, smag, clamped, root;
      longint          sum;
      int              res;
      // Fold into [-180, 180) degrees, negative angles included.
      wrapped = int'(angle) % int'(TURN_S);
      if (wrapped < 0) wrapped += int'(TURN_S);
      if (wrapped >= int'(HALF_TURN_S)) wrapped -= int'(TURN_S);
      neg_angle = wrapped < 0;
      mag       = longint'(neg_angle ? -wrapped : wrapped);
      // Degrees to radians in Q28, then the odd power series.
      x    = (mag * longint'(PI_Q32) + RAD_DIVISOR / 2) / RAD_DIVISOR;
      x2   = (x * x + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
      sum  = longint'(x);
      term = x;
      for (int k = 1; k < SERIES_TERMS; k++) begin
        d    = longint'(2 * k * (2 * k + 1));
        term = (term * x2 + (d << (Q_FRAC - 1))) / (d << Q_FRAC);
        if (k % 2 == 1) sum -= longint'(term);
        else            sum += longint'(term);
      end
      sum_neg = sum < 0;
      smag    = sum_neg ? longint'(-sum) : longint'(sum);
      if (!want_cos) begin
        res = q28_to_q15(smag);
        if (sum_neg != neg_angle) res = -res;
      end else begin
        // Clamp |sin| to one so series overshoot gives a zero cosine.
        clamped = (smag > ONE_Q28) ? ONE_Q28 : smag;
        root    = floor_sqrt(ONE_Q28 * ONE_Q28 - clamped * clamped);
        res     = q28_to_q15(root);
        if (mag > longint'(QUARTER_MAG)) res = -res;
      end
      return res[RES_W-1:0];
    endfunction

    function void note_angle(logic want_cos, logic signed [ANGLE_W-1:0] angle);
      expected_trig.push_back(predict_trig(want_cos, angle));
    endfunction

    function void check_trig(logic signed [RES_W-1:0] got);
      logic signed [RES_W-1:0] want;
      if (expected_trig.size() == 0) begin
        $error("trig_value: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = expected_trig.pop_front();
      if (got !== want) begin
        $error("trig_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_trig.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      valid_i = 1'b0;
  logic                      stall_o;
  logic                      cmd_i = 1'b0;
  logic signed [ANGLE_W-1:0] angle_deg_i = '0;
  logic                      valid_o;
  logic                      stall_i = 1'b0;
  logic signed [RES_W-1:0]   trig_value_o;

  trig_scoreboard sb = new;

  // Percent of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct  = 8;
  int rcv_stall_pct  = 60;

  degree_sine_cosine_series_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .cmd_i        (cmd_i),
    .angle_deg_i  (angle_deg_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .trig_value_o (trig_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check each accepted result word, then pick the stall for the next cycle.
  // Reads happen before this edge's updates, so they see pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) sb.check_trig(trig_value_o);
    stall_i <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // Drop the run if no word moves on either channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_MAX) begin
      @(posedge clk_i);
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one angle word, after a random idle gap, and hold it until taken.
  // Valid stays high across back-to-back words: one assignment per edge.
  task automatic send_angle(input logic want_cos, input logic signed [ANGLE_W-1:0] angle);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    cmd_i       <= want_cos;
    angle_deg_i <= angle;
    do @(posedge clk_i); while (stall_o);
    sb.note_angle(want_cos, angle);
  endtask

  // Hold off the sender until every expected result word has come back.
  task automatic wait_drained();
    valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Random angles: most uniform over the full 16 bits, some hugging the
  // quadrant edges (where sign and clamping flip), some near zero.
  task automatic send_random(input int count);
    int                        pick;
    int                        quadrant;
    int                        value;
    logic signed [ANGLE_W-1:0] angle;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        angle = ANGLE_W'($urandom());
      end else if (pick < 85) begin
        quadrant = int'($urandom_range(0, 10)) - 5;
        value    = quadrant * int'(QUARTER_MAG) + int'($urandom_range(0, 16)) - 8;
        angle    = value[ANGLE_W-1:0];
      end else begin
        value = int'($urandom_range(0, 255)) - 128;
        angle = value[ANGLE_W-1:0];
      end
      send_angle(1'($urandom_range(0, 1)), angle);
    end
  endtask

  initial begin : stimulus
    // Zero, one step off zero, both sides of 90 degrees, 180 and -180, 270,
    // -90, a full turn, and both ends of the 16-bit range.
    int directed_angles[12] = '{0, -1, 5759, 5760, 5761, 11520, -11520, 17280,
                                -5760, 23040, 32767, -32768};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: sender rarely idles, receiver stalls often.
    foreach (directed_angles[i]) begin
      send_angle(1'b0, directed_angles[i][ANGLE_W-1:0]);
      send_angle(1'b1, directed_angles[i][ANGLE_W-1:0]);
    end
    send_random(RANDOM_WORDS);
    wait_drained();

    // Phase two: sender idles often, receiver rarely stalls.
    send_idle_pct = 60;
    rcv_stall_pct = 8;
    send_random(RANDOM_WORDS);
    wait_drained();

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    send_random(RANDOM_WORDS);
    wait_drained();

    // Catch any stray word still in flight.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
